### rtl/core/aepq_pkg.sv
`default_nettype none

package aepq_pkg;

  // Parameter defaults
  localparam int MAX_LEVELS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int ID_BITS_DEF     = 10;

  // Field widths
  localparam int LEVEL_COUNT_W = 5;
  localparam int TASK_ID_W     = 10;
  localparam int DYN_LEVEL_W   = 5;
  localparam int STATIC_W      = 4;
  localparam int LEVEL_W       = 4;
  localparam int STATUS_W      = 2;

  // Stream widths, padded to whole bytes
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 16;

  // Input field positions in s_tdata
  localparam int TID_LSB    = 0;
  localparam int DYN_LSB    = TID_LSB + TASK_ID_W;
  localparam int STATIC_LSB = DYN_LSB + DYN_LEVEL_W;

  localparam logic [LEVEL_COUNT_W-1:0] LEVEL_COUNT_RST = 5'd4;

  // Dynamic level that sends an add to the expired bank
  localparam logic [DYN_LEVEL_W-1:0] DYN_EXPIRED = 5'h1F;

  localparam logic OP_ADD = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  typedef struct packed {
    status_t               status;
    logic [TASK_ID_W-1:0]  task_id;
    logic [LEVEL_W-1:0]    level;
    logic                  swapped;
  } res_t;

endpackage

`default_nettype wire

### rtl/core/aepq_ram.sv
`default_nettype none

module aepq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic                                  re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/active_expired_priority_queue_unit.sv
// Sequence: an add that fits reads the per-queue pointer memory in S_IDLE, then
//   updates it and writes the entry store in S_RMW; a get that pops also reads the
//   entry store in S_RMW and answers from S_POP; an out-of-range add or an empty
//   get answers straight from S_IDLE. Every result goes to the output register.
//   A new item is taken only in S_IDLE; a stalled result holds the input off.
// Reset (rst, synchronous, active high): all queues empty, bank zero active,
//   level count 4; the entry store is not cleared and no clearing pass runs.
`default_nettype none

module active_expired_priority_queue_unit
  import aepq_pkg::*;
#(
  parameter int MAX_LEVELS  = MAX_LEVELS_DEF,
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_we,
  input  wire logic [LEVEL_COUNT_W-1:0] cfg_wdata,   // level_count
  input  wire logic                     s_tvalid,
  output logic                          s_tready,
  // task_id[9:0], dyn_level[14:10], static_level[18:15], zero fill
  input  wire logic [IN_DATA_W-1:0]     s_tdata,
  input  wire logic                     s_tuser,     // opcode
  output logic                          m_tvalid,
  input  wire logic                     m_tready,
  // out_task_id[9:0], out_level[13:10], banks_swapped[14], zero fill
  output logic      [OUT_DATA_W-1:0]    m_tdata,
  output logic      [STATUS_W-1:0]      m_tuser      // status
);

  localparam int NQ  = 2 * MAX_LEVELS;
  localparam int QIW = $clog2(NQ);
  localparam int LVW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int PW  = $clog2(QUEUE_DEPTH);
  localparam int CW  = $clog2(QUEUE_DEPTH + 1);
  localparam int PEW = 2 * PW + CW;
  localparam int SD  = NQ * QUEUE_DEPTH;
  localparam int SAW = $clog2(SD);
  localparam int ML_CAP = (MAX_LEVELS > 31) ? 31 : MAX_LEVELS;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RMW,
    S_POP,
    S_WAIT
  } state_t;

  state_t                   state;
  logic                     active_bank;
  logic [NQ-1:0]            ne;          // queue holds entries
  logic [NQ-1:0]            vld;         // pointer entry written since reset
  logic [LEVEL_COUNT_W-1:0] level_count;
  logic                     ptr_vld_q;
  logic                     op_reg;
  logic [ID_BITS-1:0]       id_reg;
  logic [QIW-1:0]           q_reg;
  logic [LVW-1:0]           lvl_reg;
  logic                     swapped_reg;
  res_t                     pend;
  res_t                     out_res;

  // Input fields
  logic [TASK_ID_W-1:0]   in_task_id;
  logic [DYN_LEVEL_W-1:0] in_dyn;
  logic [STATIC_W-1:0]    in_static;
  logic                   in_acc;

  assign in_task_id = s_tdata[TID_LSB +: TASK_ID_W];
  assign in_dyn     = s_tdata[DYN_LSB +: DYN_LEVEL_W];
  assign in_static  = s_tdata[STATIC_LSB +: STATIC_W];
  assign s_tready   = (state == S_IDLE);
  assign in_acc     = s_tvalid && s_tready;

  // Effective level count
  logic [LEVEL_COUNT_W-1:0] n_eff;
  assign n_eff = (level_count > LEVEL_COUNT_W'(ML_CAP)) ? LEVEL_COUNT_W'(ML_CAP) : level_count;

  // Add decode: bank, level and range check
  logic                is_exp;
  logic [STATIC_W-1:0] add_lvl;
  logic                add_ok;
  logic                add_bank;
  logic [QIW-1:0]      add_q;

  assign is_exp   = (in_dyn == DYN_EXPIRED);
  assign add_lvl  = is_exp ? in_static : in_dyn[STATIC_W-1:0];
  assign add_ok   = !(in_dyn[DYN_LEVEL_W-1] && !is_exp)
                    && ({1'b0, add_lvl} < n_eff);
  assign add_bank = is_exp ? ~active_bank : active_bank;
  assign add_q    = add_bank ? QIW'(MAX_LEVELS) + QIW'(add_lvl) : QIW'(add_lvl);

  // Get decode: highest non-empty level in each bank
  logic           act_any, exp_any;
  logic [LVW-1:0] act_lvl, exp_lvl;
  logic [QIW-1:0] get_q;

  always_comb begin
    act_any = 1'b0;
    exp_any = 1'b0;
    act_lvl = '0;
    exp_lvl = '0;
    for (int l = 0; l < MAX_LEVELS; l++) begin
      if (7'(l) < {2'b00, n_eff}) begin
        if (active_bank ? ne[MAX_LEVELS + l] : ne[l]) begin
          act_any = 1'b1;
          act_lvl = LVW'(l);
        end
        if (active_bank ? ne[l] : ne[MAX_LEVELS + l]) begin
          exp_any = 1'b1;
          exp_lvl = LVW'(l);
        end
      end
    end
  end

  // The get queue lies in whichever bank is active after any swap
  always_comb begin
    if (act_any) begin
      get_q = active_bank ? QIW'(MAX_LEVELS) + QIW'(act_lvl) : QIW'(act_lvl);
    end else begin
      get_q = active_bank ? QIW'(exp_lvl) : QIW'(MAX_LEVELS) + QIW'(exp_lvl);
    end
  end

  // Pointer entry read back in the modify cycle
  logic [PEW-1:0] ptr_rdata;
  logic [PEW-1:0] ptr_entry;
  logic [PW-1:0]  ptr_head, ptr_tail;
  logic [CW-1:0]  ptr_cnt;

  assign ptr_entry = ptr_vld_q ? ptr_rdata : '0;
  assign ptr_head  = ptr_entry[PEW-1 -: PW];
  assign ptr_tail  = ptr_entry[CW +: PW];
  assign ptr_cnt   = ptr_entry[CW-1:0];

  logic [PW-1:0] head_inc, tail_inc;
  logic          q_full;
  assign head_inc = (ptr_head == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr_head + 1'b1;
  assign tail_inc = (ptr_tail == PW'(QUEUE_DEPTH - 1)) ? '0 : ptr_tail + 1'b1;
  assign q_full   = (ptr_cnt == CW'(QUEUE_DEPTH));

  // Memory controls and result selection
  logic               ptr_re, ptr_we;
  logic [QIW-1:0]     ptr_raddr;
  logic [PEW-1:0]     ptr_wdata;
  logic               st_we, st_re;
  logic [SAW-1:0]     st_waddr, st_raddr;
  logic [ID_BITS-1:0] st_rdata;
  logic               res_fire;
  res_t               res;
  logic               out_free;

  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    ptr_re    = 1'b0;
    ptr_raddr = (s_tuser == OP_ADD) ? add_q : get_q;
    ptr_we    = 1'b0;
    ptr_wdata = '0;
    st_we     = 1'b0;
    st_re     = 1'b0;
    st_waddr  = SAW'(32'(q_reg) * 32'(QUEUE_DEPTH) + 32'(ptr_tail));
    st_raddr  = SAW'(32'(q_reg) * 32'(QUEUE_DEPTH) + 32'(ptr_head));
    res_fire  = 1'b0;
    res       = '{status: ST_OK, task_id: '0, level: '0, swapped: 1'b0};
    case (state)
      S_IDLE: begin
        if (in_acc) begin
          if (s_tuser == OP_ADD) begin
            ptr_re = add_ok;
            if (!add_ok) begin
              res_fire   = 1'b1;
              res.status = ST_RANGE;
            end
          end else begin
            ptr_re = act_any || exp_any;
            if (!act_any && !exp_any) begin
              res_fire    = 1'b1;
              res.status  = ST_EMPTY;
              res.swapped = 1'b1;
            end
          end
        end
      end
      S_RMW: begin
        if (op_reg == OP_ADD) begin
          res_fire  = 1'b1;
          res.level = LEVEL_W'(lvl_reg);
          if (q_full) begin
            res.status = ST_FULL;
          end else begin
            st_we     = 1'b1;
            ptr_we    = 1'b1;
            ptr_wdata = {ptr_head, tail_inc, ptr_cnt + 1'b1};
          end
        end else begin
          st_re     = 1'b1;
          ptr_we    = 1'b1;
          ptr_wdata = {head_inc, ptr_tail, ptr_cnt - 1'b1};
        end
      end
      S_POP: begin
        res_fire    = 1'b1;
        res.task_id = TASK_ID_W'(st_rdata);
        res.level   = LEVEL_W'(lvl_reg);
        res.swapped = swapped_reg;
      end
      S_WAIT: begin
        res_fire = 1'b1;
        res      = pend;
      end
      default: begin
        res_fire = 1'b0;
      end
    endcase
  end

  // Per-queue head, tail and count
  aepq_ram #(
    .WIDTH (PEW),
    .DEPTH (NQ)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (q_reg),
    .wdata (ptr_wdata),
    .re    (ptr_re),
    .raddr (ptr_raddr),
    .rdata (ptr_rdata)
  );

  // Queue entries
  aepq_ram #(
    .WIDTH (ID_BITS),
    .DEPTH (SD)
  ) u_store_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (id_reg),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Sequencer, bank state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      m_tvalid    <= 1'b0;
      active_bank <= 1'b0;
      ne          <= '0;
      vld         <= '0;
      level_count <= LEVEL_COUNT_RST;
    end else begin
      if (cfg_we) begin
        level_count <= cfg_wdata;
      end
      case (state)
        S_IDLE: begin
          if (in_acc) begin
            op_reg    <= s_tuser;
            id_reg    <= ID_BITS'(in_task_id);
            ptr_vld_q <= vld[ptr_raddr];
            q_reg     <= ptr_raddr;
            if (s_tuser == OP_ADD) begin
              lvl_reg     <= LVW'(add_lvl);
              swapped_reg <= 1'b0;
              if (add_ok) begin
                state <= S_RMW;
              end
            end else begin
              lvl_reg     <= act_any ? act_lvl : exp_lvl;
              swapped_reg <= !act_any;
              if (!act_any) begin
                active_bank <= ~active_bank;
              end
              if (act_any || exp_any) begin
                state <= S_RMW;
              end
            end
          end
        end
        S_RMW: begin
          if (op_reg == OP_ADD) begin
            if (!q_full) begin
              ne[q_reg]  <= 1'b1;
              vld[q_reg] <= 1'b1;
            end
          end else begin
            ne[q_reg] <= (ptr_cnt != CW'(1));
            state     <= S_POP;
          end
        end
        S_POP: begin
          // Result handed on below
        end
        S_WAIT: begin
          // Result handed on below
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // Hand the result to the output register, or hold it until it frees up
      if (res_fire && out_free) begin
        m_tvalid <= 1'b1;
        out_res  <= res;
        state    <= S_IDLE;
      end else begin
        if (m_tvalid && m_tready) begin
          m_tvalid <= 1'b0;
        end
        if (res_fire) begin
          pend  <= res;
          state <= S_WAIT;
        end
      end
    end
  end

  assign m_tdata = {1'b0, out_res.swapped, out_res.level, out_res.task_id};
  assign m_tuser = out_res.status;

`ifndef ASSERT_OFF
  // Non-empty bitmap agrees with the stored count
  a_ne_matches_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW) |-> ((ptr_cnt != '0) == ne[q_reg]))
    else $error("non-empty bit disagrees with queue count");

  // Count never passes the queue depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_RMW) |-> (ptr_cnt <= CW'(QUEUE_DEPTH)))
    else $error("queue count beyond depth");

  // An empty get always swaps and carries no id or level
  a_empty_swaps: assert property (@(posedge clk) disable iff (rst)
    (res_fire && res.status == ST_EMPTY) |->
      (res.swapped && res.task_id == '0 && res.level == '0))
    else $error("empty get without swap");

  // An accepted item is either in work or already answered
  a_item_kept: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> ((state != S_IDLE) || m_tvalid))
    else $error("accepted item lost");
`endif

endmodule

`default_nettype wire
